// ----- hdl/satsched_pkg.sv -----
// Shared types and constants for the shortest average turnaround scheduler.
// No dependencies.
package satsched_pkg;

  localparam int PROCESSES  = 4;
  localparam int HISTORY    = 8;
  localparam int TIME_WIDTH = 32;

  localparam int PROC_W     = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int SLOT_W     = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int CNT_W      = $clog2(HISTORY + 1);
  localparam int ADDR_W     = PROC_W + SLOT_W;
  localparam int DIV_STEP   = 8;
  localparam int DIV_CHUNKS = TIME_WIDTH / DIV_STEP;
  localparam int CHUNK_W    = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_DIV  = 5'b00100,
    S_ACC  = 5'b01000,
    S_PICK = 5'b10000
  } state_t;

  typedef enum logic {
    KIND_DONE    = 1'b0,
    KIND_PREEMPT = 1'b1
  } kind_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] elapsed_us;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  next_process;
    logic [31:0] average_turnaround;
    logic [15:0] completed_count;
  } out_beat_t;

endpackage

// ----- hdl/shortest_average_turnaround_scheduler.sv -----
// Shortest average turnaround scheduler: history ring, per-sample divide, argmin.
// Depends on satsched_pkg.
// Each sample costs one history read, four 8-bit divide steps and one accumulate.
// Search walks the averages one compare per cycle; one beat in flight,
// the next beat may be taken in the strobe cycle. Reset: synchronous active low; clears
// counts, averages, ring pointers; history undefined.
module shortest_average_turnaround_scheduler (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  satsched_pkg::in_beat_t in_data,
  output logic                   busy,
  output logic                   out_valid,
  output satsched_pkg::out_beat_t out_data
);
  import satsched_pkg::*;

  state_t                state_r, state_nxt;
  logic [PROC_W-1:0]     cur_r, cur_nxt;
  logic [SLOT_W-1:0]     wslot_r [PROCESSES];
  logic [SLOT_W-1:0]     wslot_nxt [PROCESSES];
  logic [CNT_W-1:0]      filled_r [PROCESSES];
  logic [CNT_W-1:0]      filled_nxt [PROCESSES];
  logic [TIME_WIDTH-1:0] avg_r [PROCESSES];
  logic [TIME_WIDTH-1:0] avg_nxt [PROCESSES];
  logic [15:0]           jobs_r, jobs_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [CHUNK_W-1:0]    chunk_r, chunk_nxt;
  logic [PROC_W-1:0]     pick_r, pick_nxt;
  logic [PROC_W-1:0]     best_r, best_nxt;
  logic                  have_r, have_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [TIME_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [TIME_WIDTH-1:0] acc_r, acc_nxt;
  logic [TIME_WIDTH-1:0] best_val_r, best_val_nxt;
  logic [TIME_WIDTH-1:0] res_avg_r, res_avg_nxt;
  out_beat_t             out_r, out_nxt;

  logic [TIME_WIDTH-1:0] hist_mem [2**ADDR_W];
  logic                  mem_we;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;

  logic                  accept;
  logic [CNT_W-1:0]      n_cur;
  logic [CNT_W-1:0]      k_inc;
  logic [TIME_WIDTH-1:0] acc_sum;
  logic [TIME_WIDTH-1:0] pick_val;
  logic                  take;
  logic [PROC_W-1:0]     best_sel;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign n_cur     = filled_r[cur_r];
  assign k_inc     = k_r + CNT_W'(1);
  assign acc_sum   = acc_r + dvd_r;
  assign pick_val  = avg_r[pick_r];
  assign take      = (pick_r != cur_r) && (!have_r || (pick_val <= best_val_r));
  assign best_sel  = take ? pick_r : best_r;
  assign mem_we    = accept && (in_data.kind == KIND_DONE);
  assign wr_addr   = {cur_r, wslot_r[cur_r]};
  assign rd_addr   = {cur_r, k_r[SLOT_W-1:0]};

  // radix-2 restoring divide by the fill count, DIV_STEP bits per cycle
  always_comb begin
    logic [CNT_W:0]        sh;
    logic                  q;
    logic [CNT_W-1:0]      rem_v;
    logic [TIME_WIDTH-1:0] dvd_v;
    rem_v = rem_r;
    dvd_v = dvd_r;
    for (int j = 0; j < DIV_STEP; j++) begin
      sh = {rem_v, dvd_v[TIME_WIDTH-1]};
      q  = (sh >= {1'b0, n_cur});
      if (q) begin
        sh = sh - {1'b0, n_cur};
      end
      rem_v = sh[CNT_W-1:0];
      dvd_v = {dvd_v[TIME_WIDTH-2:0], q};
    end
    rem_nxt = rem_v;
    dvd_nxt = dvd_v;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    wslot_nxt     = wslot_r;
    filled_nxt    = filled_r;
    avg_nxt       = avg_r;
    jobs_nxt      = jobs_r;
    k_nxt         = k_r;
    chunk_nxt     = chunk_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    have_nxt      = have_r;
    out_valid_nxt = 1'b0;
    acc_nxt       = acc_r;
    best_val_nxt  = best_val_r;
    res_avg_nxt   = res_avg_r;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pick_nxt = '0;
          have_nxt = 1'b0;
          if (in_data.kind == KIND_DONE) begin
            wslot_nxt[cur_r] = (wslot_r[cur_r] == SLOT_W'(HISTORY - 1)) ? '0 :
                               wslot_r[cur_r] + SLOT_W'(1);
            if (filled_r[cur_r] < CNT_W'(HISTORY)) begin
              filled_nxt[cur_r] = filled_r[cur_r] + CNT_W'(1);
            end
            jobs_nxt  = jobs_r + 16'd1;
            k_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = S_READ;
          end else begin
            if (filled_r[cur_r] == '0) begin
              avg_nxt[cur_r] = {1'b0, in_data.elapsed_us[TIME_WIDTH-1:1]};
            end
            state_nxt = S_PICK;
          end
        end
      end
      S_READ: begin
        chunk_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        chunk_nxt = chunk_r + CHUNK_W'(1);
        if (chunk_r == CHUNK_W'(DIV_CHUNKS - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        acc_nxt = acc_sum;
        k_nxt   = k_inc;
        if (k_inc == n_cur) begin
          avg_nxt[cur_r] = acc_sum;
          state_nxt      = S_PICK;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_PICK: begin
        best_nxt = best_sel;
        if (take) begin
          best_val_nxt = pick_val;
          have_nxt     = 1'b1;
        end
        if (pick_r == cur_r) begin
          res_avg_nxt = pick_val;
        end
        pick_nxt = pick_r + PROC_W'(1);
        if (pick_r == PROC_W'(PROCESSES - 1)) begin
          out_valid_nxt              = 1'b1;
          out_nxt.next_process       = 2'(best_sel);
          out_nxt.average_turnaround = (pick_r == cur_r) ? pick_val : res_avg_r;
          out_nxt.completed_count    = jobs_r;
          cur_nxt                    = best_sel;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      jobs_r      <= '0;
      k_r         <= '0;
      chunk_r     <= '0;
      pick_r      <= '0;
      best_r      <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PROCESSES; i++) begin
        wslot_r[i]  <= '0;
        filled_r[i] <= '0;
        avg_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      jobs_r      <= jobs_nxt;
      k_r         <= k_nxt;
      chunk_r     <= chunk_nxt;
      pick_r      <= pick_nxt;
      best_r      <= best_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      wslot_r     <= wslot_nxt;
      filled_r    <= filled_nxt;
      avg_r       <= avg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= (state_r == S_DIV) ? rem_nxt : '0;
    acc_r      <= acc_nxt;
    best_val_r <= best_val_nxt;
    res_avg_r  <= res_avg_nxt;
    out_r      <= out_nxt;
  end

  // history ring; read data lands in the dividend register
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wr_addr] <= in_data.elapsed_us[TIME_WIDTH-1:0];
    end
    if (state_r == S_READ) begin
      dvd_r <= hist_mem[rd_addr];
    end else if (state_r == S_DIV) begin
      dvd_r <= dvd_nxt;
    end
  end

endmodule

// ----- hdl/satsched_chk.sv -----
// Port-level checker for the scheduler, bound to the top level.
// Depends on satsched_pkg and shortest_average_turnaround_scheduler.
module satsched_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input satsched_pkg::out_beat_t out_data
);
  import satsched_pkg::*;

  // a beat is taken into work at once, never answered in the same cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted beat did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_valid && (out_data.next_process < PROCESSES)))
    else $error("work finished without a result beat");

endmodule

bind shortest_average_turnaround_scheduler satsched_chk u_satsched_chk (.*);
